>>> rtl/vnbd_pkg.sv
// Package for the von Neumann bit debiaser: payload structs, register
// indexes and sizing constants. No dependencies.
package vnbd_pkg;

  localparam int unsigned NUM_PINS = 6;
  localparam int unsigned ADC_BITS = 10;

  localparam logic [15:0] LIMIT_RESET = 16'd16;
  localparam logic [5:0]  BYTE_BITS   = 6'd8;
  localparam logic [5:0]  WORD_BITS   = 6'd32;
  localparam logic [3:0]  LAST_PIN    = 4'(NUM_PINS - 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_LIMIT = 2'd0;
  localparam logic [1:0] REG_MODE  = 2'd1;

  typedef struct packed {
    logic [ADC_BITS-1:0] first_sample;
    logic [ADC_BITS-1:0] second_sample;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  pin_select;
    logic        word_done;
    logic        word_failed;
    logic [31:0] word_value;
  } out_req_t;

  // Least significant bits of one sample pair.
  typedef struct packed {
    logic first_bit;
    logic second_bit;
  } bit_pair_t;

  // Configuration write as seen by the state logic.
  typedef struct packed {
    logic        we;
    logic [1:0]  idx;
    logic [15:0] data;
  } cfg_wr_t;

endpackage

>>> rtl/vnbd_in_reg.sv
// Input register of the debiaser: keeps the sample bits of one request.
// Depends on vnbd_pkg.
module vnbd_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vnbd_pkg::in_req_t  in_req_i,
  input  logic               advance_i,
  output logic               valid_o,
  output vnbd_pkg::bit_pair_t pair_o
);
  import vnbd_pkg::*;

  logic      valid_q, valid_d;
  bit_pair_t pair_q;

  // Only bit 0 of each sample matters, so only that bit is stored.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pair_q.first_bit  <= in_req_i.first_sample[0];
      pair_q.second_bit <= in_req_i.second_sample[0];
    end
  end

  assign valid_o = valid_q;
  assign pair_o  = pair_q;

endmodule

>>> rtl/vnbd_state.sv
// Debiaser state and per-pair logic: pin rotation, try counter, word
// accumulator and configuration registers. Depends on vnbd_pkg.
module vnbd_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  vnbd_pkg::bit_pair_t pair_i,
  input  vnbd_pkg::cfg_wr_t   cfg_i,
  output vnbd_pkg::out_req_t  res_o
);
  import vnbd_pkg::*;

  logic [3:0]  pin_q, pin_d;
  logic [15:0] tries_q, tries_d;
  logic [5:0]  bits_q, bits_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] limit_q, limit_d;
  logic        mode_q, mode_d;

  logic [31:0] acc_shift;
  logic [5:0]  bits_inc;
  logic [5:0]  target;
  logic [3:0]  pin_next;
  logic        differ;
  logic        done;
  logic        failed;

  assign differ    = pair_i.first_bit ^ pair_i.second_bit;
  assign acc_shift = {acc_q[30:0], pair_i.second_bit};
  assign bits_inc  = bits_q + 6'd1;
  assign target    = mode_q ? WORD_BITS : BYTE_BITS;
  assign pin_next  = (pin_q >= LAST_PIN) ? 4'd0 : pin_q + 4'd1;
  assign done      = differ && (bits_inc >= target);
  // A limit of zero behaves like one: the first matching pair fails.
  assign failed    = !differ && (tries_q <= 16'd1);

  always_comb begin
    res_o.pin_select  = pin_next;
    res_o.word_done   = done;
    res_o.word_failed = failed;
    res_o.word_value  = 32'd0;
    if (done) begin
      res_o.word_value = mode_q ? acc_shift : {24'd0, acc_shift[7:0]};
    end
  end

  always_comb begin
    pin_d   = pin_q;
    tries_d = tries_q;
    bits_d  = bits_q;
    acc_d   = acc_q;
    limit_d = limit_q;
    mode_d  = mode_q;
    if (cfg_i.we) begin
      case (cfg_i.idx)
        REG_LIMIT: begin
          limit_d = cfg_i.data;
          tries_d = cfg_i.data;
        end
        REG_MODE: begin
          mode_d  = cfg_i.data[0];
          acc_d   = 32'd0;
          bits_d  = 6'd0;
          tries_d = limit_q;
        end
        default: begin
        end
      endcase
    end else if (step_i) begin
      pin_d = pin_next;
      if (differ) begin
        tries_d = limit_q;
        if (done) begin
          acc_d  = 32'd0;
          bits_d = 6'd0;
        end else begin
          acc_d  = acc_shift;
          bits_d = bits_inc;
        end
      end else if (failed) begin
        acc_d   = 32'd0;
        bits_d  = 6'd0;
        tries_d = limit_q;
      end else begin
        tries_d = tries_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q   <= 4'd0;
      tries_q <= LIMIT_RESET;
      bits_q  <= 6'd0;
      acc_q   <= 32'd0;
      limit_q <= LIMIT_RESET;
      mode_q  <= 1'b1;
    end else begin
      pin_q   <= pin_d;
      tries_q <= tries_d;
      bits_q  <= bits_d;
      acc_q   <= acc_d;
      limit_q <= limit_d;
      mode_q  <= mode_d;
    end
  end

endmodule

>>> rtl/vnbd_out_reg.sv
// Result register of the debiaser: holds one result request until taken.
// Depends on vnbd_pkg.
module vnbd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  vnbd_pkg::out_req_t res_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vnbd_pkg::out_req_t out_req_o
);
  import vnbd_pkg::*;

  logic     valid_q, valid_d;
  out_req_t data_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (can_load_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = data_q;

endmodule

>>> rtl/von_neumann_bit_debiaser_core.sv
// Requests go through the input register, then the result register. One
// sample pair per cycle while results are taken; the per-pair logic is one
// compare, a 32-bit shift and a 16-bit count between the two registers.
// Reset clears both pipeline valids, the pin index and the word state, and
// sets the try limit and try count to 16 and the word mode to 32-bit words.
module von_neumann_bit_debiaser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vnbd_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vnbd_pkg::out_req_t out_req_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import vnbd_pkg::*;

  // The input register holds the least significant bits of one request. The
  // pair is consumed when the result register can take its result; at that
  // same edge the state logic advances and the result is captured. Both
  // stages accept a new request while the stage after them is draining, so
  // a steady stream moves one pair per cycle.
  logic      pair_valid;
  bit_pair_t pair;
  logic      can_load;
  logic      step;
  out_req_t  res;
  cfg_wr_t   cfg;

  assign step = pair_valid && can_load;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  vnbd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .advance_i  (step),
    .valid_o    (pair_valid),
    .pair_o     (pair)
  );

  // Configuration writes are to arrive only while no request is in flight;
  // the block does not enforce this, and the state logic gives writes priority.
  vnbd_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .pair_i (pair),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  vnbd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

`ifndef SYNTHESIS
  // A result is either a finished word or a failed one, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_req_o.word_done && out_req_o.word_failed))
    else $error("result marked both done and failed");

  // The word value is zero unless the word completed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_req_o.word_done) |-> (out_req_o.word_value == 32'd0))
    else $error("nonzero word value without word_done");

  // The announced pin stays within the pin range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.pin_select <= LAST_PIN))
    else $error("pin index out of range");

  // A consumed pair always leaves a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("consumed pair produced no result");
`endif

endmodule

>>> tb/sv/debiaser_word_checker.sv
// Checker for the von Neumann bit debiaser: predicts one result per sample
// pair and compares it with the block's output stream.
// Depends on vnbd_pkg for the payload structs, register indexes and constants.
module debiaser_word_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  vnbd_pkg::in_req_t  in_req_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  vnbd_pkg::out_req_t out_req_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  output int                 errors_o,
  output int                 outstanding_o
);
  import vnbd_pkg::*;

  // Predicted register and word state.
  logic [15:0] try_limit;
  logic        wide_words;
  logic [3:0]  next_pin;
  logic [15:0] tries_left;
  logic [5:0]  bits_taken;
  logic [31:0] word_bits;

  out_req_t expected_words_q[$];
  int       fail_count = 0;

  assign errors_o = fail_count;

  function automatic void drop_word();
    word_bits  = '0;
    bits_taken = '0;
    tries_left = try_limit;
  endfunction

  // Advances the predicted state by one sample pair and returns its result.
  function automatic out_req_t debias_pair(input in_req_t pair);
    out_req_t   res;
    logic [3:0] pin;
    logic [5:0] word_len;
    res      = '0;
    word_len = wide_words ? WORD_BITS : BYTE_BITS;
    pin      = next_pin + 4'd1;
    if (pin >= NUM_PINS) pin = '0;
    next_pin = pin;
    if (pair.first_sample[0] != pair.second_sample[0]) begin
      word_bits  = {word_bits[30:0], pair.second_sample[0]};
      bits_taken = bits_taken + 6'd1;
      tries_left = try_limit;
      if (bits_taken >= word_len) begin
        res.word_done  = 1'b1;
        res.word_value = wide_words ? word_bits : {24'd0, word_bits[7:0]};
        drop_word();
      end
    end else if (tries_left <= 16'd1) begin
      res.word_failed = 1'b1;
      drop_word();
    end else begin
      tries_left = tries_left - 16'd1;
    end
    res.pin_select = next_pin;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_req_t want;
    if (!rst_ni) begin
      try_limit  = LIMIT_RESET;
      wide_words = 1'b1;
      next_pin   = '0;
      drop_word();
      expected_words_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LIMIT: begin
            try_limit  = cfg_wdata_i;
            tries_left = try_limit;
          end
          REG_MODE: begin
            wide_words = cfg_wdata_i[0];
            drop_word();
          end
          default: ;
        endcase
      end
      // Results are matched before new pairs are queued, so a stray result
      // can never be paired with a request accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_words_q.size() == 0) begin
          $error("result with no request outstanding: %p", out_req_i);
          fail_count++;
        end else begin
          want = expected_words_q.pop_front();
          if (out_req_i.pin_select !== want.pin_select) begin
            $error("pin_select: expected %0d, got %0d", want.pin_select,
                   out_req_i.pin_select);
            fail_count++;
          end
          if (out_req_i.word_done !== want.word_done) begin
            $error("word_done: expected %0d, got %0d", want.word_done,
                   out_req_i.word_done);
            fail_count++;
          end
          if (out_req_i.word_failed !== want.word_failed) begin
            $error("word_failed: expected %0d, got %0d", want.word_failed,
                   out_req_i.word_failed);
            fail_count++;
          end
          if (out_req_i.word_value !== want.word_value) begin
            $error("word_value: expected %08h, got %08h", want.word_value,
                   out_req_i.word_value);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_words_q.push_back(debias_pair(in_req_i));
    end
    outstanding_o <= expected_words_q.size();
  end

endmodule

>>> tb/sv/tb_von_neumann_bit_debiaser_core.sv
// Testbench top for von_neumann_bit_debiaser_core: drives sample-pair
// requests and register writes, and gives the verdict.
// Depends on vnbd_pkg, the core and debiaser_word_checker.
module tb_von_neumann_bit_debiaser_core;
  import vnbd_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 60;
  // Cycles that settle() still waits once every result is back, before the
  // block counts as idle.
  localparam int SETTLE_CYCLES   = 6;
  localparam int IDLE_PCT        = 31;
  localparam int NUM_PHASES      = 7;

  // Indexes that decode to no register; writes to them must be ignored.
  localparam logic [1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [1:0] REG_UNUSED_3 = 2'd3;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_req_t     in_req    = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_req_t    out_req;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = REG_LIMIT;
  logic [15:0] cfg_wdata = '0;

  int errors;
  int outstanding;
  int cycle_count = 0;
  int pairs_sent  = 0;
  int reg_writes  = 0;

  // Shared between the request side and the result side: steady_flow turns
  // off random idling on both, hold_off_pending asks the result side for one
  // long stall.
  logic steady_flow      = 1'b0;
  logic hold_off_pending = 1'b0;

  // Random phases: try limit, word mode, number of pairs, percentage of
  // pairs with equal low bits, and whether the phase runs without idling.
  int phase_limit  [NUM_PHASES] = '{16, 1, 65535, 3, 0, 2, 5};
  int phase_mode   [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 0};
  int phase_items  [NUM_PHASES] = '{90, 60, 80, 70, 50, 60, 40};
  int phase_eq_pct [NUM_PHASES] = '{50, 30, 50, 60, 20, 40, 50};
  int phase_steady [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 0};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  von_neumann_bit_debiaser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  debiaser_word_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_req_i      (in_req),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_req_i     (out_req),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  function automatic in_req_t pair_of(input logic [9:0] first, input logic [9:0] second);
    in_req_t p;
    p.first_sample  = first;
    p.second_sample = second;
    return p;
  endfunction

  // Random samples over the full 10-bit range; only the low bit of the
  // second sample is steered, so that the share of rejected pairs can be set.
  function automatic in_req_t random_pair(input int eq_pct);
    in_req_t p;
    p.first_sample  = 10'($urandom_range(1023));
    p.second_sample = 10'($urandom_range(1023));
    p.second_sample[0] = ($urandom_range(99) < eq_pct) ? p.first_sample[0]
                                                       : ~p.first_sample[0];
    return p;
  endfunction

  // Offers one request and returns at the edge where it is accepted. Valid
  // stays high between back-to-back requests; it is lowered only for idle
  // cycles, so it never gets two assignments in one time step.
  task automatic offer_pair(input in_req_t p);
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_req   <= p;
    do @(posedge clk_i); while (!in_ready);
    pairs_sent++;
  endtask

  // Stops offering and waits until every predicted result has come back.
  // The first edge lets the checker count a request accepted at the last one.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  // Only bit 0 of the mode register counts; the upper bits carry noise.
  task automatic set_mode(input logic wide);
    write_reg(REG_MODE, {15'($urandom_range(32767)), wide});
  endtask

  // The result side: accepts results at random, or without pause while the
  // stimulus asks for steady flow. When asked, it holds off for a long
  // stretch, counted here, so that the core fills up and stalls its input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: a run that hangs, or leaves a result missing, ends here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** von_neumann_bit_debiaser_core: FAILED **");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part at the reset settings (limit 16, 32-bit words): sample
    // extremes, pairs whose low bits differ, and a pair whose upper
    // bits differ while the low bits match.
    offer_pair(pair_of(10'h000, 10'h000));
    offer_pair(pair_of(10'h3FF, 10'h3FF));
    offer_pair(pair_of(10'h000, 10'h3FF));
    offer_pair(pair_of(10'h3FF, 10'h000));
    offer_pair(pair_of(10'h3FE, 10'h001));
    offer_pair(pair_of(10'h001, 10'h3FE));
    offer_pair(pair_of(10'h2AA, 10'h155));
    offer_pair(pair_of(10'h155, 10'h2AB));
    settle();

    // Writes to undecoded indexes must leave the partial word alone. Then a
    // zero limit, which must act as a limit of one, and a switch to 8-bit
    // words, which drops the partial word.
    write_reg(REG_UNUSED_2, 16'hFFFF);
    write_reg(REG_UNUSED_3, 16'h0000);
    write_reg(REG_LIMIT, 16'h0000);
    set_mode(1'b0);
    offer_pair(pair_of(10'h0F0, 10'h00E));
    // Eight accepted bits make one byte, first bit most significant.
    offer_pair(pair_of(10'h000, 10'h001));
    offer_pair(pair_of(10'h001, 10'h000));
    offer_pair(pair_of(10'h000, 10'h3FF));
    offer_pair(pair_of(10'h2AA, 10'h155));
    offer_pair(pair_of(10'h3FF, 10'h3FE));
    offer_pair(pair_of(10'h001, 10'h200));
    offer_pair(pair_of(10'h100, 10'h0FF));
    offer_pair(pair_of(10'h155, 10'h2AA));
    settle();

    // A rejected pair uses one try; rewriting the limit then reloads the
    // count at once, and an accepted bit reloads it again before the word
    // fails on the third rejected pair that follows it.
    write_reg(REG_LIMIT, 16'd2);
    offer_pair(pair_of(10'h000, 10'h3FE));
    settle();
    write_reg(REG_LIMIT, 16'd3);
    offer_pair(pair_of(10'h001, 10'h3FF));
    offer_pair(pair_of(10'h001, 10'h002));
    offer_pair(pair_of(10'h3FF, 10'h001));
    offer_pair(pair_of(10'h200, 10'h000));
    offer_pair(pair_of(10'h002, 10'h3FC));

    // Random phases over several limits, both word modes and the extremes
    // of the limit register.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_reg(REG_LIMIT, 16'(phase_limit[ph]));
      set_mode(phase_mode[ph] != 0);
      steady_flow = (phase_steady[ph] != 0);
      for (int n = 0; n < phase_items[ph]; n++) begin
        // In the first phase the result side stalls for a long stretch while
        // requests keep coming, and later the request side pauses until
        // every result is back.
        if (ph == 0 && n == 20) hold_off_pending = 1'b1;
        if (ph == 0 && n == 60) settle();
        offer_pair(random_pair(phase_eq_pct[ph]));
      end
      steady_flow = 1'b0;
    end
    settle();

    $display("Run covered %0d sample pairs and %0d register writes: limits 0 to 65535,",
             pairs_sent, reg_writes);
    $display("8- and 32-bit words, ignored register indexes and a long output stall.");
    if (errors == 0) begin
      $display("** von_neumann_bit_debiaser_core: PASSED **");
    end else begin
      $display("** von_neumann_bit_debiaser_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/vnbd_pkg.sv
rtl/vnbd_in_reg.sv
rtl/vnbd_state.sv
rtl/vnbd_out_reg.sv
rtl/von_neumann_bit_debiaser_core.sv
tb/sv/debiaser_word_checker.sv
tb/sv/tb_von_neumann_bit_debiaser_core.sv
